@@ rtl/lavm_pkg.sv @@
// Shared constants and types for the look-at view matrix pipeline.
`timescale 1ns / 1ps
package lavm_pkg;
   localparam int Q_ONE      = 16384;
   localparam int MAG_W      = 31;  // component magnitude, up to 2^30
   localparam int SQ_W       = 62;  // sum of three squares
   localparam int ROOT_W     = 31;
   localparam int REM_W      = 35;
   localparam int SQRT_STEPS = 31;
   localparam int QBITS      = 15;  // quotient up to 16384
   localparam int NUM_W      = 45;
   localparam int NORM_TOP   = 29;  // leading one goes to bit 29
   localparam int NORM_LAT   = 4 + SQRT_STEPS + 1 + QBITS + 1;
   localparam int XPROD_LAT  = 2;
   localparam int DOT_LAT    = 3;

   typedef logic signed [15:0] q14_type;
   typedef logic signed [31:0] q16_type;
endpackage

@@ rtl/lavm_delay.sv @@
// Enabled shift-register delay line for payload.
`timescale 1ns / 1ps
module lavm_delay #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic             en,
   input  logic [WIDTH-1:0] d,
   output logic [WIDTH-1:0] q
);
   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (en) begin
         tap_ff[0] <= d;
         for (int i = 1; i < DEPTH; i++) begin
            tap_ff[i] <= tap_ff[i-1];
         end
      end
   end

   assign q = tap_ff[DEPTH-1];
endmodule

@@ rtl/lavm_norm.sv @@
// Pipelined 3-vector normalizer: prescale, squares, bitwise root, restoring divide.
`timescale 1ns / 1ps
module lavm_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [31:0]   in_v [3],
   output logic                 out_valid,
   output lavm_pkg::q14_type    out_q [3]
);
   localparam int NS = lavm_pkg::SQRT_STEPS;
   localparam int QB = lavm_pkg::QBITS;

   // prescale stages
   logic                          v0_ff, v1_ff, v2_ff, v3_ff;
   logic [lavm_pkg::MAG_W-1:0]    mag_ff [3];
   logic [2:0]                    neg0_ff, neg1_ff, neg2_ff, neg3_ff;
   logic [lavm_pkg::MAG_W-1:0]    a1_ff [3];
   logic [lavm_pkg::MAG_W-1:0]    a2_ff [3];
   logic [lavm_pkg::MAG_W-1:0]    a3_ff [3];
   logic                          z1_ff, z2_ff, z3_ff;
   logic [lavm_pkg::SQ_W-1:0]     sq_ff [3];

   // max and shift search
   logic [lavm_pkg::MAG_W-1:0]    max_in;
   logic [4:0]                    msb_in;
   logic [4:0]                    sh_in;

   always_comb begin
      max_in = mag_ff[0];
      if (mag_ff[1] > max_in) max_in = mag_ff[1];
      if (mag_ff[2] > max_in) max_in = mag_ff[2];
      msb_in = '0;
      for (int b = 0; b < lavm_pkg::MAG_W; b++) begin
         if (max_in[b]) msb_in = 5'(b);
      end
      sh_in = (msb_in < 5'(lavm_pkg::NORM_TOP)) ? 5'(lavm_pkg::NORM_TOP) - msb_in : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            mag_ff[i]  <= in_v[i][31] ? 31'(-in_v[i]) : in_v[i][30:0];
            neg0_ff[i] <= in_v[i][31];
            a1_ff[i]   <= mag_ff[i] << sh_in;
            sq_ff[i]   <= lavm_pkg::SQ_W'(a1_ff[i]) * lavm_pkg::SQ_W'(a1_ff[i]);
            a2_ff[i]   <= a1_ff[i];
            a3_ff[i]   <= a2_ff[i];
         end
         neg1_ff <= neg0_ff;
         neg2_ff <= neg1_ff;
         neg3_ff <= neg2_ff;
         z1_ff   <= (max_in == '0);
         z2_ff   <= z1_ff;
         z3_ff   <= z2_ff;
      end
   end

   logic [lavm_pkg::SQ_W-1:0] n3_ff;
   always_ff @(posedge clock) begin
      if (en) n3_ff <= sq_ff[0] + sq_ff[1] + sq_ff[2];
   end

   // square root, one result bit per stage
   logic                           rv_ff   [0:NS];
   logic [lavm_pkg::REM_W-1:0]     rem_ff  [0:NS];
   logic [lavm_pkg::ROOT_W-1:0]    root_ff [0:NS];
   logic [lavm_pkg::SQ_W-1:0]      rn_ff   [0:NS];
   logic [lavm_pkg::MAG_W-1:0]     ra_ff   [0:NS][3];
   logic [2:0]                     rneg_ff [0:NS];
   logic                           rz_ff   [0:NS];

   always_comb begin
      rv_ff[0]   = v3_ff;
      rem_ff[0]  = '0;
      root_ff[0] = '0;
      rn_ff[0]   = n3_ff;
      ra_ff[0]   = a3_ff;
      rneg_ff[0] = neg3_ff;
      rz_ff[0]   = z3_ff;
   end

   for (genvar j = 0; j < NS; j++) begin : g_sqrt
      logic [lavm_pkg::REM_W-1:0] sh_rem;
      logic [lavm_pkg::REM_W-1:0] trial;
      logic                       take;
      assign sh_rem = {rem_ff[j][lavm_pkg::REM_W-3:0], rn_ff[j][lavm_pkg::SQ_W-1 -: 2]};
      assign trial  = lavm_pkg::REM_W'({root_ff[j], 2'b01});
      assign take   = (sh_rem >= trial);
      always_ff @(posedge clock) begin
         if (reset) begin
            rv_ff[j+1] <= 1'b0;
         end else if (en) begin
            rv_ff[j+1] <= rv_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j+1]  <= take ? sh_rem - trial : sh_rem;
            root_ff[j+1] <= {root_ff[j][lavm_pkg::ROOT_W-2:0], take};
            rn_ff[j+1]   <= rn_ff[j] << 2;
            ra_ff[j+1]   <= ra_ff[j];
            rneg_ff[j+1] <= rneg_ff[j];
            rz_ff[j+1]   <= rz_ff[j];
         end
      end
   end

   // restoring divide, one quotient bit per stage
   logic                          dv_ff   [0:QB];
   logic [lavm_pkg::ROOT_W-1:0]   ds_ff   [0:QB];
   logic [lavm_pkg::NUM_W-1:0]    drem_ff [0:QB][3];
   logic [QB-1:0]                 dq_ff   [0:QB][3];
   logic [2:0]                    dneg_ff [0:QB];
   logic                          dz_ff   [0:QB];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= rv_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ds_ff[0]   <= root_ff[NS];
         dneg_ff[0] <= rneg_ff[NS];
         dz_ff[0]   <= rz_ff[NS];
         for (int i = 0; i < 3; i++) begin
            drem_ff[0][i] <= {ra_ff[NS][i], 14'd0}
                           + lavm_pkg::NUM_W'(root_ff[NS] >> 1);
            dq_ff[0][i]   <= '0;
         end
      end
   end

   for (genvar d = 0; d < QB; d++) begin : g_div
      localparam int J = QB - 1 - d;
      logic [lavm_pkg::NUM_W-1:0] dsh;
      assign dsh = lavm_pkg::NUM_W'(ds_ff[d]) << J;
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[d+1] <= 1'b0;
         end else if (en) begin
            dv_ff[d+1] <= dv_ff[d];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            ds_ff[d+1]   <= ds_ff[d];
            dneg_ff[d+1] <= dneg_ff[d];
            dz_ff[d+1]   <= dz_ff[d];
            for (int i = 0; i < 3; i++) begin
               if (drem_ff[d][i] >= dsh) begin
                  drem_ff[d+1][i] <= drem_ff[d][i] - dsh;
                  dq_ff[d+1][i]   <= dq_ff[d][i] | (QB'(1) << J);
               end else begin
                  drem_ff[d+1][i] <= drem_ff[d][i];
                  dq_ff[d+1][i]   <= dq_ff[d][i];
               end
            end
         end
      end
   end

   // clamp, sign, zero vector
   logic              ov_ff;
   lavm_pkg::q14_type oq_ff [3];
   logic [QB-1:0]     clamp_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         clamp_in[i] = (dq_ff[QB][i] > QB'(lavm_pkg::Q_ONE)) ? QB'(lavm_pkg::Q_ONE)
                                                              : dq_ff[QB][i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= 1'b0;
      end else if (en) begin
         ov_ff <= dv_ff[QB];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            if (dz_ff[QB]) begin
               oq_ff[i] <= '0;
            end else if (dneg_ff[QB][i]) begin
               oq_ff[i] <= -$signed({1'b0, clamp_in[i]});
            end else begin
               oq_ff[i] <= $signed({1'b0, clamp_in[i]});
            end
         end
      end
   end

   assign out_valid = ov_ff;
   assign out_q     = oq_ff;
endmodule

@@ rtl/lavm_dot.sv @@
// Three-stage negated dot product, rounded to Q16.16 and saturated.
`timescale 1ns / 1ps
module lavm_dot (
   input  logic              clock,
   input  logic              en,
   input  lavm_pkg::q14_type a [3],
   input  lavm_pkg::q16_type b [3],
   output lavm_pkg::q16_type t
);
   logic signed [47:0] prod_ff [3];
   logic signed [49:0] sum_ff;
   lavm_pkg::q16_type  t_ff;

   logic signed [50:0] neg_in;
   logic signed [36:0] rnd_in;

   always_comb begin
      neg_in = 51'sd8192 - 51'(sum_ff);
      rnd_in = 37'(neg_in >>> 14);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            prod_ff[i] <= 48'(a[i]) * 48'(b[i]);
         end
         sum_ff <= 50'(prod_ff[0]) + 50'(prod_ff[1]) + 50'(prod_ff[2]);
         if (rnd_in > 37'sd2147483647) begin
            t_ff <= 32'sh7fffffff;
         end else if (rnd_in < -37'sd2147483648) begin
            t_ff <= 32'sh80000000;
         end else begin
            t_ff <= rnd_in[31:0];
         end
      end
   end

   assign t = t_ff;
endmodule

@@ rtl/look_at_view_matrix.sv @@
// Top level: left-handed look-at view matrix, one matrix per beat.
// Pipeline: req beat to rsp beat through two 52-stage normalizers,
//   a 2-stage cross product and 3-stage dot products.
// Throughput: one beat per cycle; the whole pipe advances whenever the
//   output register is empty or being taken.
// Reset: synchronous, clears all valid bits; payload is not reset.
`timescale 1ns / 1ps
module look_at_view_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // look_x, look_y, look_z, eye_x, eye_y, eye_z (lowest bit up)
   input  logic [143:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // right_x/y/z, up_x/y/z, fwd_x/y/z, trans_x/y/z (lowest bit up)
   output logic [239:0] rsp_tdata
);
   localparam int T_R = lavm_pkg::NORM_LAT;
   localparam int T_X = lavm_pkg::NORM_LAT + lavm_pkg::XPROD_LAT;
   localparam int T_U = T_X + lavm_pkg::NORM_LAT;

   // global advance: stall everything when the output beat is held
   logic en;
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   lavm_pkg::q14_type look_in [3];
   lavm_pkg::q16_type eye_in  [3];
   logic signed [31:0] rr_in  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         look_in[i] = req_tdata[16*i +: 16];
         eye_in[i]  = req_tdata[48 + 32*i +: 32];
      end
      // Y x look = (lz, 0, -lx)
      rr_in[0] = 32'(look_in[2]);
      rr_in[1] = '0;
      rr_in[2] = -32'(look_in[0]);
   end

   // right vector
   logic              rv_out;
   lavm_pkg::q14_type r_out [3];
   lavm_norm u_norm_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_v      (rr_in),
      .out_valid (rv_out),
      .out_q     (r_out)
   );

   // look aligned with right
   logic [47:0] look_r;
   lavm_delay #(.WIDTH(48), .DEPTH(T_R)) u_dly_look_r (
      .clock (clock),
      .en    (en),
      .d     (req_tdata[47:0]),
      .q     (look_r)
   );

   lavm_pkg::q14_type lr [3];
   always_comb begin
      for (int i = 0; i < 3; i++) lr[i] = look_r[16*i +: 16];
   end

   // up = look x right, products then differences
   logic               xv1_ff, xv2_ff;
   logic signed [31:0] p_ff [6];
   logic signed [31:0] ur_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         xv1_ff <= 1'b0;
         xv2_ff <= 1'b0;
      end else if (en) begin
         xv1_ff <= rv_out;
         xv2_ff <= xv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0]  <= 32'(lr[1]) * 32'(r_out[2]);
         p_ff[1]  <= 32'(lr[2]) * 32'(r_out[1]);
         p_ff[2]  <= 32'(lr[2]) * 32'(r_out[0]);
         p_ff[3]  <= 32'(lr[0]) * 32'(r_out[2]);
         p_ff[4]  <= 32'(lr[0]) * 32'(r_out[1]);
         p_ff[5]  <= 32'(lr[1]) * 32'(r_out[0]);
         ur_ff[0] <= p_ff[0] - p_ff[1];
         ur_ff[1] <= p_ff[2] - p_ff[3];
         ur_ff[2] <= p_ff[4] - p_ff[5];
      end
   end

   logic              uv_out;
   lavm_pkg::q14_type u_out [3];
   lavm_norm u_norm_u (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xv2_ff),
      .in_v      (ur_ff),
      .out_valid (uv_out),
      .out_q     (u_out)
   );

   // align right, look and eye with up
   logic [47:0] r_flat, r_u, look_u;
   logic [95:0] eye_u;
   always_comb begin
      for (int i = 0; i < 3; i++) r_flat[16*i +: 16] = r_out[i];
   end

   lavm_delay #(.WIDTH(48), .DEPTH(T_X)) u_dly_r (
      .clock (clock),
      .en    (en),
      .d     (r_flat),
      .q     (r_u)
   );
   lavm_delay #(.WIDTH(48), .DEPTH(T_X)) u_dly_look_u (
      .clock (clock),
      .en    (en),
      .d     (look_r),
      .q     (look_u)
   );
   lavm_delay #(.WIDTH(96), .DEPTH(T_U)) u_dly_eye (
      .clock (clock),
      .en    (en),
      .d     (req_tdata[143:48]),
      .q     (eye_u)
   );

   lavm_pkg::q14_type ra [3], la [3];
   lavm_pkg::q16_type ea [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ra[i] = r_u[16*i +: 16];
         la[i] = look_u[16*i +: 16];
         ea[i] = eye_u[32*i +: 32];
      end
   end

   lavm_pkg::q16_type tx, ty, tz;
   lavm_dot u_dot_x (.clock(clock), .en(en), .a(ra),    .b(ea), .t(tx));
   lavm_dot u_dot_y (.clock(clock), .en(en), .a(u_out), .b(ea), .t(ty));
   lavm_dot u_dot_z (.clock(clock), .en(en), .a(la),    .b(ea), .t(tz));

   // vectors ride along with the dot pipes
   logic [143:0] vec_u, vec_o;
   always_comb begin
      vec_u[47:0]   = r_u;
      for (int i = 0; i < 3; i++) vec_u[48 + 16*i +: 16] = u_out[i];
      vec_u[143:96] = look_u;
   end

   lavm_delay #(.WIDTH(144), .DEPTH(lavm_pkg::DOT_LAT)) u_dly_vec (
      .clock (clock),
      .en    (en),
      .d     (vec_u),
      .q     (vec_o)
   );

   logic [lavm_pkg::DOT_LAT-1:0] ov_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ov_ff <= '0;
      end else if (en) begin
         ov_ff <= {ov_ff[lavm_pkg::DOT_LAT-2:0], uv_out};
      end
   end

   assign rsp_tvalid = ov_ff[lavm_pkg::DOT_LAT-1];
   assign rsp_tdata  = {tz, ty, tx, vec_o};
endmodule

@@ rtl/lavm_chk.sv @@
// Port-level checker for the look-at view matrix, bound to the top level.
`timescale 1ns / 1ps
module lavm_chk (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [239:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid || rsp_tready |-> req_tready)
      else $error("req stalled with free output");

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[15:0]) <= 16'sd16384)
                  && ($signed(rsp_tdata[15:0]) >= -16'sd16384)
                  && ($signed(rsp_tdata[63:48]) <= 16'sd16384)
                  && ($signed(rsp_tdata[63:48]) >= -16'sd16384))
      else $error("unit vector component out of range");
endmodule

bind look_at_view_matrix lavm_chk u_lavm_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the look-at view matrix block.
`timescale 1ns / 1ps
module tb_top;
   localparam int PIPE_LAT    = 109;
   localparam int CYCLE_LIMIT = 400000;
   localparam int N_RANDOM    = 530;

   typedef struct packed {
      lavm_pkg::q16_type eye_z, eye_y, eye_x;
      lavm_pkg::q14_type look_z, look_y, look_x;
   } view_req_type;

   typedef struct packed {
      lavm_pkg::q16_type trans_z, trans_y, trans_x;
      lavm_pkg::q14_type fwd_z, fwd_y, fwd_x;
      lavm_pkg::q14_type up_z, up_y, up_x;
      lavm_pkg::q14_type right_z, right_y, right_x;
   } view_mat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [143:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [239:0] rsp_tdata;

   look_at_view_matrix DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   view_req_type pending_reqs[$];   // items waiting to be offered
   view_mat_type expected_mats[$];  // predicted matrices, oldest first
   int  error_count = 0;
   int  cycle_count = 0;
   bit  stim_done = 0;
   bit  calm_phase = 0;   // no idling in the final stretch
   bit  drain_hold = 0;   // sender waits for the pipe to empty
   bit  stall_go = 0;     // request for the long receiver stall
   bit  stall_used = 0;
   int  hold_off = 0;     // receiver long-stall countdown
   int  tx_gap = 0, rx_gap = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   // isqrt of a 64-bit value, bit by bit
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= res + bitv) begin
            n -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // Scale largest magnitude into [2^29,2^30), then rounded divide by floor root.
   function automatic void unit_vec(input longint v[3], output longint o[3]);
      longint unsigned a[3], m, n2, s, q;
      m = 0;
      n2 = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = (v[i] < 0) ? -v[i] : v[i];
         if (a[i] > m) m = a[i];
      end
      if (m == 0) begin
         for (int i = 0; i < 3; i++) o[i] = 0;
         return;
      end
      while (m < 64'd536870912) begin
         m <<= 1;
         for (int i = 0; i < 3; i++) a[i] <<= 1;
      end
      for (int i = 0; i < 3; i++) n2 += a[i] * a[i];
      s = int_sqrt(n2);
      for (int i = 0; i < 3; i++) begin
         q = (a[i] * lavm_pkg::Q_ONE + s / 2) / s;
         if (q > lavm_pkg::Q_ONE) q = lavm_pkg::Q_ONE;
         o[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   // -(d.e) rounded to Q16.16, ties up, saturated
   function automatic lavm_pkg::q16_type neg_dot(input longint d[3], input longint e[3]);
      longint sum, x, t;
      sum = d[0] * e[0] + d[1] * e[1] + d[2] * e[2];
      x = -sum + 8192;
      t = (x >= 0) ? x / 16384 : -((-x + 16383) / 16384);
      if (t > 64'sd2147483647) t = 64'sd2147483647;
      if (t < -64'sd2147483648) t = -64'sd2147483648;
      return lavm_pkg::q16_type'(t);
   endfunction

   function automatic view_mat_type build_view(view_req_type r);
      longint l[3], e[3], rr[3], rt[3], ur[3], up[3];
      view_mat_type m;
      l[0] = r.look_x; l[1] = r.look_y; l[2] = r.look_z;
      e[0] = r.eye_x;  e[1] = r.eye_y;  e[2] = r.eye_z;
      rr[0] = l[2]; rr[1] = 0; rr[2] = -l[0];
      unit_vec(rr, rt);
      ur[0] = l[1] * rt[2] - l[2] * rt[1];
      ur[1] = l[2] * rt[0] - l[0] * rt[2];
      ur[2] = l[0] * rt[1] - l[1] * rt[0];
      unit_vec(ur, up);
      m.right_x = lavm_pkg::q14_type'(rt[0]);
      m.right_y = lavm_pkg::q14_type'(rt[1]);
      m.right_z = lavm_pkg::q14_type'(rt[2]);
      m.up_x = lavm_pkg::q14_type'(up[0]);
      m.up_y = lavm_pkg::q14_type'(up[1]);
      m.up_z = lavm_pkg::q14_type'(up[2]);
      m.fwd_x = r.look_x; m.fwd_y = r.look_y; m.fwd_z = r.look_z;
      m.trans_x = neg_dot(rt, e);
      m.trans_y = neg_dot(up, e);
      m.trans_z = neg_dot(l, e);
      return m;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      $display("mismatch %s: got %0d want %0d (cycle %0d)", field, got, want, cycle_count);
      error_count++;
   endtask

   function automatic lavm_pkg::q14_type pick_look();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sd0;
         3: return lavm_pkg::q14_type'($urandom_range(0, 8)) - 16'sd4;
         default: return lavm_pkg::q14_type'($urandom);
      endcase
   endfunction

   function automatic lavm_pkg::q16_type pick_eye();
      case ($urandom_range(0, 4))
         0: return 32'sh80000000;
         1: return 32'sh7fffffff;
         2: return lavm_pkg::q16_type'($urandom_range(0, 2000000)) - 32'sd1000000;
         default: return lavm_pkg::q16_type'($urandom);
      endcase
   endfunction

   function automatic view_req_type mk_req(longint lx, longint ly, longint lz,
                                           longint ex, longint ey, longint ez);
      view_req_type r;
      r.look_x = lavm_pkg::q14_type'(lx);
      r.look_y = lavm_pkg::q14_type'(ly);
      r.look_z = lavm_pkg::q14_type'(lz);
      r.eye_x = lavm_pkg::q16_type'(ex);
      r.eye_y = lavm_pkg::q16_type'(ey);
      r.eye_z = lavm_pkg::q16_type'(ez);
      return r;
   endfunction

   // Stimulus: directed corners, then random beats.
   initial begin
      view_req_type r;
      // zero look, look along +/-Y (degenerate right/up)
      pending_reqs.push_back(mk_req(0, 0, 0, 32'sh10000, 32'sh20000, 32'sh30000));
      pending_reqs.push_back(mk_req(0, 16384, 0, 32'sh7fffffff, 0, 32'sh80000000));
      pending_reqs.push_back(mk_req(0, -16384, 0, 1, -1, 5));
      pending_reqs.push_back(mk_req(0, 16'sh7fff, 0, -7, 9, 11));
      // axis-aligned looks
      pending_reqs.push_back(mk_req(0, 0, 16384, 32'sh10000, 32'sh10000, 32'sh10000));
      pending_reqs.push_back(mk_req(0, 0, -16384, 0, 0, 32'sh7fffffff));
      pending_reqs.push_back(mk_req(16384, 0, 0, 32'sh80000000, 0, 0));
      pending_reqs.push_back(mk_req(-16384, 0, 0, 3, 4, 5));
      // field extremes, translation saturation
      pending_reqs.push_back(mk_req(16'sh8000, 16'sh8000, 16'sh8000,
                                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_reqs.push_back(mk_req(16'sh7fff, 16'sh7fff, 16'sh7fff,
                                    32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
      pending_reqs.push_back(mk_req(16'sh7fff, 16'sh7fff, 16'sh7fff,
                                    32'sh80000000, 32'sh80000000, 32'sh80000000));
      pending_reqs.push_back(mk_req(16'sh8000, 16'sh7fff, 16'sh8000,
                                    32'sh80000000, 32'sh7fffffff, 32'sh80000000));
      pending_reqs.push_back(mk_req(-1, -1, -1, -1, -1, -1));
      pending_reqs.push_back(mk_req(1, 0, 1, 1, 1, 1));
      pending_reqs.push_back(mk_req(1, 16'sh7fff, 0, 0, 0, 0));
      pending_reqs.push_back(mk_req(16'sh8000, 0, 16'sh7fff, 32'sh2000, -32'sh2000, 8191));
      pending_reqs.push_back(mk_req(11585, 0, 11585, 32'sh12345678, 32'sh9abcdef0, 0));
      for (int i = 0; i < N_RANDOM; i++) begin
         r = mk_req(pick_look(), pick_look(), pick_look(), pick_eye(), pick_eye(), pick_eye());
         // now and then force Y-parallel looks
         if ($urandom_range(0, 19) == 0) begin
            r.look_x = '0;
            r.look_z = '0;
         end
         pending_reqs.push_back(r);
      end
   end

   // Driver: the queue head is the beat on the bus until it is taken
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_mats.push_back(build_view(view_req_type'(req_tdata)));
            void'(pending_reqs.pop_front());
         end
         if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!(req_tvalid && !req_tready) && pending_reqs.size() == 0) begin
            req_tvalid <= 1'b0;
            stim_done <= 1'b1;
         end else if (req_tvalid && !req_tready) begin
            req_tvalid <= 1'b1;   // hold the beat
         end else if (drain_hold) begin
            req_tvalid <= 1'b0;
         end else if (!calm_phase && $urandom_range(0, 9) == 0) begin
            req_tvalid <= 1'b0;
            tx_gap <= $urandom_range(0, 3);
         end else begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_reqs[0];
         end
      end
   end

   // Long receiver stall, counted here
   always @(posedge clock) begin
      if (stall_go && !stall_used) begin
         stall_used <= 1'b1;
         hold_off <= 400;
      end else if (hold_off > 0) begin
         hold_off <= hold_off - 1;
      end
   end

   // Receiver readiness: random bursts, one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off > 0) begin
         rsp_tready <= 1'b0;
      end else if (rx_gap > 0) begin
         rx_gap <= rx_gap - 1;
         rsp_tready <= 1'b0;
      end else if (!calm_phase && $urandom_range(0, 7) == 0) begin
         rsp_tready <= 1'b0;
         rx_gap <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor
   always @(posedge clock) begin
      view_mat_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = view_mat_type'(rsp_tdata);
         if (expected_mats.size() == 0) begin
            $display("unexpected matrix beat at cycle %0d", cycle_count);
            error_count++;
         end else begin
            want = expected_mats.pop_front();
            if (got.right_x !== want.right_x) report_mismatch("right_x", got.right_x, want.right_x);
            if (got.right_y !== want.right_y) report_mismatch("right_y", got.right_y, want.right_y);
            if (got.right_z !== want.right_z) report_mismatch("right_z", got.right_z, want.right_z);
            if (got.up_x !== want.up_x) report_mismatch("up_x", got.up_x, want.up_x);
            if (got.up_y !== want.up_y) report_mismatch("up_y", got.up_y, want.up_y);
            if (got.up_z !== want.up_z) report_mismatch("up_z", got.up_z, want.up_z);
            if (got.fwd_x !== want.fwd_x) report_mismatch("fwd_x", got.fwd_x, want.fwd_x);
            if (got.fwd_y !== want.fwd_y) report_mismatch("fwd_y", got.fwd_y, want.fwd_y);
            if (got.fwd_z !== want.fwd_z) report_mismatch("fwd_z", got.fwd_z, want.fwd_z);
            if (got.trans_x !== want.trans_x) report_mismatch("trans_x", got.trans_x, want.trans_x);
            if (got.trans_y !== want.trans_y) report_mismatch("trans_y", got.trans_y, want.trans_y);
            if (got.trans_z !== want.trans_z) report_mismatch("trans_z", got.trans_z, want.trans_z);
         end
      end
   end

   // Phase control and end of run
   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // long receiver stall while the sender keeps offering: fills the pipe
      wait (cycle_count > 300);
      @(posedge clock);
      stall_go <= 1'b1;
      wait (cycle_count > 1200);
      // sender pauses until every expected matrix is out
      @(posedge clock);
      drain_hold <= 1'b1;
      repeat (2) @(posedge clock);
      wait (expected_mats.size() == 0 && !req_tvalid);
      @(posedge clock);
      drain_hold <= 1'b0;
      wait (pending_reqs.size() < 60);
      @(posedge clock);
      calm_phase <= 1'b1;
      wait (stim_done && expected_mats.size() == 0);
      repeat (PIPE_LAT + 20) @(posedge clock);
      if (error_count == 0 && expected_mats.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // Watchdog
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
